// File: rtl/bsrp_pkg.sv
// Package for the hypothesis stack: command/status structs, FSM states,
// result and command codes, saturating add. No dependencies.
package bsrp_pkg;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [2:0] OC_ADDED    = 3'd0;
    localparam logic [2:0] OC_REPLACED = 3'd1;
    localparam logic [2:0] OC_DROPPED  = 3'd2;
    localparam logic [2:0] OC_BELOW    = 3'd3;
    localparam logic [2:0] OC_EVICTED  = 3'd4;
    localparam logic [2:0] OC_CLEARED  = 3'd5;
    localparam logic [2:0] OC_BEST     = 3'd6;
    localparam logic [2:0] OC_EMPTY    = 3'd7;

    localparam logic [1:0] REG_BEAM    = 2'd0;
    localparam logic [1:0] REG_LIMIT   = 2'd1;
    localparam logic [1:0] REG_PDIS    = 2'd2;

    localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISP, ST_EBW, ST_RD, ST_CHK, ST_ADEC, ST_UPD,
        ST_PCHK, ST_POST, ST_CLR, ST_QEMIT, ST_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        SM_MATCH, SM_COUNT, SM_SEL, SM_EVICT, SM_QUERY
    } t_scan_mode;

    typedef enum logic [3:0] {
        DP_NOP, DP_CAP, DP_CHK, DP_EMIT_BW, DP_DROP, DP_REPL, DP_INS,
        DP_UPD, DP_PR_INIT, DP_SEL_INIT, DP_SEL_NEXT, DP_SEL_DONE,
        DP_EV_END, DP_CLR, DP_EMIT_Q, DP_FLUSH
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        t_scan_mode mode;
    } t_ctl_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       below_worst;
        logic       match_f;
        logic       better;
        logic       free_f;
        logic       idx_last;
        logic       cand_zero;
        logic       sel_done;
        logic       evict_hit;
        logic       rdy;
        logic       out_free;
        logic       need_prune;
    } t_dp_status;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s > 33'sd2147483647)       sat_add = 32'sh7FFF_FFFF;
        else if (s < -33'sd2147483648) sat_add = SCORE_MIN;
        else                           sat_add = s[31:0];
    endfunction

endpackage

// File: rtl/bsrp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bsrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// File: rtl/bsrp_ctrl.sv
// Sequencer for the hypothesis stack: walks the slot scans and issues
// datapath operations. Depends on bsrp_pkg.
module bsrp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  bsrp_pkg::t_dp_status  i_st,
    output bsrp_pkg::t_ctl_cmd    o_cmd
);
    bsrp_pkg::t_state     r_state, n_state;
    bsrp_pkg::t_scan_mode r_mode,  n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsrp_pkg::ST_IDLE;
            r_mode  <= bsrp_pkg::SM_MATCH;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        o_cmd.op   = bsrp_pkg::DP_NOP;
        o_cmd.mode = r_mode;
        o_stall    = (r_state != bsrp_pkg::ST_IDLE);
        case (r_state)
            bsrp_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = bsrp_pkg::DP_CAP;
                    n_state  = bsrp_pkg::ST_DISP;
                end
            end
            bsrp_pkg::ST_DISP: begin
                case (i_st.cmd)
                    bsrp_pkg::CMD_ADD: begin
                        if (i_st.below_worst) n_state = bsrp_pkg::ST_EBW;
                        else begin
                            n_mode  = bsrp_pkg::SM_MATCH;
                            n_state = bsrp_pkg::ST_RD;
                        end
                    end
                    bsrp_pkg::CMD_CLEAR: n_state = bsrp_pkg::ST_CLR;
                    bsrp_pkg::CMD_QUERY: begin
                        n_mode  = bsrp_pkg::SM_QUERY;
                        n_state = bsrp_pkg::ST_RD;
                    end
                    default: n_state = bsrp_pkg::ST_IDLE;
                endcase
            end
            bsrp_pkg::ST_EBW: begin
                if (i_st.rdy) begin
                    o_cmd.op = bsrp_pkg::DP_EMIT_BW;
                    n_state  = bsrp_pkg::ST_FLUSH;
                end
            end
            bsrp_pkg::ST_RD: n_state = bsrp_pkg::ST_CHK;
            bsrp_pkg::ST_CHK: begin
                // an eviction emits a word, so it waits for room
                if (!(r_mode == bsrp_pkg::SM_EVICT && i_st.evict_hit && !i_st.rdy)) begin
                    o_cmd.op = bsrp_pkg::DP_CHK;
                    n_state  = i_st.idx_last ? bsrp_pkg::ST_POST : bsrp_pkg::ST_RD;
                end
            end
            bsrp_pkg::ST_POST: begin
                case (r_mode)
                    bsrp_pkg::SM_MATCH: n_state = bsrp_pkg::ST_ADEC;
                    bsrp_pkg::SM_QUERY: n_state = bsrp_pkg::ST_QEMIT;
                    bsrp_pkg::SM_COUNT: begin
                        if (i_st.cand_zero) n_state = bsrp_pkg::ST_FLUSH;
                        else begin
                            o_cmd.op = bsrp_pkg::DP_SEL_INIT;
                            n_mode   = bsrp_pkg::SM_SEL;
                            n_state  = bsrp_pkg::ST_RD;
                        end
                    end
                    bsrp_pkg::SM_SEL: begin
                        if (i_st.sel_done) begin
                            o_cmd.op = bsrp_pkg::DP_SEL_DONE;
                            n_mode   = bsrp_pkg::SM_EVICT;
                        end else begin
                            o_cmd.op = bsrp_pkg::DP_SEL_NEXT;
                        end
                        n_state = bsrp_pkg::ST_RD;
                    end
                    bsrp_pkg::SM_EVICT: begin
                        o_cmd.op = bsrp_pkg::DP_EV_END;
                        n_state  = bsrp_pkg::ST_FLUSH;
                    end
                    default: n_state = bsrp_pkg::ST_FLUSH;
                endcase
            end
            bsrp_pkg::ST_ADEC: begin
                if (i_st.rdy) begin
                    if (i_st.match_f) begin
                        if (i_st.better) begin
                            o_cmd.op = bsrp_pkg::DP_REPL;
                            n_state  = bsrp_pkg::ST_UPD;
                        end else begin
                            o_cmd.op = bsrp_pkg::DP_DROP;
                            n_state  = bsrp_pkg::ST_FLUSH;
                        end
                    end else if (!i_st.free_f) begin
                        o_cmd.op = bsrp_pkg::DP_EMIT_BW;
                        n_state  = bsrp_pkg::ST_FLUSH;
                    end else begin
                        o_cmd.op = bsrp_pkg::DP_INS;
                        n_state  = bsrp_pkg::ST_UPD;
                    end
                end
            end
            bsrp_pkg::ST_UPD: begin
                o_cmd.op = bsrp_pkg::DP_UPD;
                n_state  = bsrp_pkg::ST_PCHK;
            end
            bsrp_pkg::ST_PCHK: begin
                if (i_st.need_prune) begin
                    o_cmd.op = bsrp_pkg::DP_PR_INIT;
                    n_mode   = bsrp_pkg::SM_COUNT;
                    n_state  = bsrp_pkg::ST_RD;
                end else begin
                    n_state = bsrp_pkg::ST_FLUSH;
                end
            end
            bsrp_pkg::ST_CLR: begin
                if (i_st.rdy) begin
                    o_cmd.op = bsrp_pkg::DP_CLR;
                    n_state  = bsrp_pkg::ST_FLUSH;
                end
            end
            bsrp_pkg::ST_QEMIT: begin
                if (i_st.rdy) begin
                    o_cmd.op = bsrp_pkg::DP_EMIT_Q;
                    n_state  = bsrp_pkg::ST_FLUSH;
                end
            end
            bsrp_pkg::ST_FLUSH: begin
                if (i_st.out_free) begin
                    o_cmd.op = bsrp_pkg::DP_FLUSH;
                    n_state  = bsrp_pkg::ST_IDLE;
                end
            end
            default: n_state = bsrp_pkg::ST_IDLE;
        endcase
    end
endmodule

// File: rtl/bsrp_dp.sv
// Datapath for the hypothesis stack: slot RAM, valid bits, scan
// accumulators, kth-best selection, pending and output words.
// Depends on bsrp_pkg and bsrp_ram.
module bsrp_dp #(
    parameter int MAX_KEEP = 16,
    parameter int KEY_BITS = 32,
    parameter int ID_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [31:0]                 i_cfg_data,
    input  logic [1:0]                  i_cmd,
    input  logic [ID_BITS-1:0]          i_hypo_id,
    input  logic [KEY_BITS-1:0]         i_recomb_key,
    input  logic signed [31:0]          i_new_score,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [2:0]                  o_outcome,
    output logic [15:0]                 o_entry_id,
    output logic signed [31:0]          o_entry_score,
    output logic [5:0]                  o_entries_held,
    output logic                        o_last,
    input  bsrp_pkg::t_ctl_cmd          i_ctl,
    output bsrp_pkg::t_dp_status        o_st
);
    localparam int S  = 2 * MAX_KEEP;
    localparam int IW = $clog2(S);
    localparam int CW = $clog2(S + 1);
    localparam int WW = KEY_BITS + 32 + ID_BITS;

    // config
    logic signed [31:0] r_beam;
    logic [4:0]         r_lim;
    logic               r_pdis;
    // captured input
    logic [1:0]          r_cmd;
    logic [ID_BITS-1:0]  r_id;
    logic [KEY_BITS-1:0] r_key;
    logic signed [31:0]  r_sc;
    // stack state
    logic [S-1:0]        r_valid;
    logic [CW-1:0]       r_held;
    logic signed [31:0]  r_best, r_worst, r_bthr;
    // scan
    logic [IW-1:0]       r_idx, r_midx, r_fidx;
    logic                r_match_f, r_free_f, r_qf;
    logic [ID_BITS-1:0]  r_mid, r_qid;
    logic signed [31:0]  r_msc, r_qsc;
    // selection
    logic [CW-1:0]       r_cnt, r_rem, r_maxcnt;
    logic signed [31:0]  r_cur, r_max, r_thr;
    logic                r_first, r_max_f;
    // pending and output words
    logic                r_pv, r_ov, r_olast;
    logic [2:0]          r_poc, r_ooc;
    logic [15:0]         r_pid, r_oid;
    logic signed [31:0]  r_psc, r_osc;
    logic [CW-1:0]       r_pheld, r_oheld;

    logic [WW-1:0]       ram_q, ram_wd;
    logic [IW-1:0]       ram_wa;
    logic                ram_we;
    logic [KEY_BITS-1:0] q_key;
    logic signed [31:0]  q_sc;
    logic [ID_BITS-1:0]  q_id;
    logic                q_v, q_cand, evict_hit, out_free;
    logic [CW-1:0]       lim_eff, k_val;

    logic                emit;
    logic [2:0]          e_oc;
    logic [15:0]         e_id;
    logic signed [31:0]  e_sc;
    logic [CW-1:0]       e_held;
    logic signed [31:0]  b_new;

    bsrp_ram #(.WIDTH(WW), .DEPTH(S)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(r_idx),
        .o_rdata(ram_q)
    );

    assign q_id  = ram_q[ID_BITS-1:0];
    assign q_sc  = ram_q[ID_BITS +: 32];
    assign q_key = ram_q[ID_BITS+32 +: KEY_BITS];
    assign q_v   = r_valid[r_idx];
    assign q_cand = (r_beam == bsrp_pkg::SCORE_MIN) || (q_sc > r_bthr);
    assign evict_hit = q_v && (q_sc < r_thr);
    assign out_free  = !r_ov || !i_stall;

    always_comb begin
        if (r_lim == 5'd0)                      lim_eff = CW'(1);
        else if (32'(r_lim) > 32'(MAX_KEEP))    lim_eff = CW'(MAX_KEEP);
        else                                    lim_eff = CW'(r_lim);
        k_val = (lim_eff < r_cnt) ? lim_eff : r_cnt;
    end

    assign ram_we = (i_ctl.op == bsrp_pkg::DP_REPL) || (i_ctl.op == bsrp_pkg::DP_INS);
    assign ram_wa = (i_ctl.op == bsrp_pkg::DP_REPL) ? r_midx : r_fidx;
    assign ram_wd = {r_key, r_sc, r_id};
    assign b_new  = bsrp_pkg::sat_add(r_sc, r_beam);

    always_comb begin
        emit   = 1'b1;
        e_oc   = bsrp_pkg::OC_ADDED;
        e_id   = 16'(r_id);
        e_sc   = r_sc;
        e_held = r_held;
        case (i_ctl.op)
            bsrp_pkg::DP_EMIT_BW: e_oc = bsrp_pkg::OC_BELOW;
            bsrp_pkg::DP_DROP: begin
                e_oc = bsrp_pkg::OC_DROPPED; e_id = 16'(r_mid); e_sc = r_msc;
            end
            bsrp_pkg::DP_REPL: begin
                e_oc = bsrp_pkg::OC_REPLACED; e_id = 16'(r_mid); e_sc = r_msc;
            end
            bsrp_pkg::DP_INS: e_held = r_held + CW'(1);
            bsrp_pkg::DP_CLR: begin
                e_oc = bsrp_pkg::OC_CLEARED; e_id = 16'd0; e_sc = 32'sd0;
                e_held = '0;
            end
            bsrp_pkg::DP_EMIT_Q: begin
                if (r_qf) begin
                    e_oc = bsrp_pkg::OC_BEST; e_id = 16'(r_qid); e_sc = r_qsc;
                end else begin
                    e_oc = bsrp_pkg::OC_EMPTY; e_id = 16'd0; e_sc = 32'sd0;
                end
            end
            bsrp_pkg::DP_CHK: begin
                emit   = (i_ctl.mode == bsrp_pkg::SM_EVICT) && evict_hit;
                e_oc   = bsrp_pkg::OC_EVICTED;
                e_id   = 16'(q_id);
                e_sc   = q_sc;
                e_held = r_held - CW'(1);
            end
            default: emit = 1'b0;
        endcase
    end

    always_comb begin
        o_st.cmd         = r_cmd;
        o_st.below_worst = r_sc < r_worst;
        o_st.match_f     = r_match_f;
        o_st.better      = r_sc > r_msc;
        o_st.free_f      = r_free_f;
        o_st.idx_last    = (r_idx == IW'(S - 1));
        o_st.cand_zero   = (r_cnt == '0);
        o_st.sel_done    = (r_maxcnt >= r_rem);
        o_st.evict_hit   = evict_hit;
        o_st.rdy         = !r_pv || out_free;
        o_st.out_free    = out_free;
        o_st.need_prune  = !r_pdis && ({1'b0, r_held} >= {lim_eff, 1'b0});
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam  <= bsrp_pkg::SCORE_MIN;
            r_lim   <= 5'd16;
            r_pdis  <= 1'b0;
            r_valid <= '0;
            r_held  <= '0;
            r_best  <= bsrp_pkg::SCORE_MIN;
            r_worst <= bsrp_pkg::SCORE_MIN;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bsrp_pkg::REG_BEAM:  r_beam <= i_cfg_data;
                    bsrp_pkg::REG_LIMIT: r_lim  <= i_cfg_data[4:0];
                    bsrp_pkg::REG_PDIS:  r_pdis <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (i_ctl.op)
                bsrp_pkg::DP_INS: begin
                    r_valid[r_fidx] <= 1'b1;
                    r_held          <= r_held + CW'(1);
                end
                bsrp_pkg::DP_CLR: begin
                    r_valid <= '0;
                    r_held  <= '0;
                end
                bsrp_pkg::DP_CHK: begin
                    if (i_ctl.mode == bsrp_pkg::SM_EVICT && evict_hit) begin
                        r_valid[r_idx] <= 1'b0;
                        r_held         <= r_held - CW'(1);
                    end
                end
                bsrp_pkg::DP_UPD: begin
                    if (r_sc > r_best) begin
                        r_best <= r_sc;
                        if (r_beam != bsrp_pkg::SCORE_MIN && b_new > r_worst)
                            r_worst <= b_new;
                    end
                end
                bsrp_pkg::DP_EV_END: r_worst <= r_thr;
                default: ;
            endcase
            // output register drains; pending word moves ahead on emit or flush
            if ((emit && r_pv) || i_ctl.op == bsrp_pkg::DP_FLUSH) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (emit) r_pv <= 1'b1;
            else if (i_ctl.op == bsrp_pkg::DP_FLUSH) r_pv <= 1'b0;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if ((emit && r_pv) || i_ctl.op == bsrp_pkg::DP_FLUSH) begin
            r_ooc   <= r_poc;
            r_oid   <= r_pid;
            r_osc   <= r_psc;
            r_oheld <= r_pheld;
            r_olast <= (i_ctl.op == bsrp_pkg::DP_FLUSH);
        end
        if (emit) begin
            r_poc   <= e_oc;
            r_pid   <= e_id;
            r_psc   <= e_sc;
            r_pheld <= e_held;
        end
        case (i_ctl.op)
            bsrp_pkg::DP_CAP: begin
                r_cmd     <= i_cmd;
                r_id      <= i_hypo_id;
                r_key     <= i_recomb_key;
                r_sc      <= i_new_score;
                r_idx     <= '0;
                r_match_f <= 1'b0;
                r_free_f  <= 1'b0;
                r_qf      <= 1'b0;
            end
            bsrp_pkg::DP_PR_INIT: begin
                r_bthr <= bsrp_pkg::sat_add(r_best, r_beam);
                r_cnt  <= '0;
                r_idx  <= '0;
            end
            bsrp_pkg::DP_SEL_INIT: begin
                r_rem    <= k_val;
                r_first  <= 1'b1;
                r_max_f  <= 1'b0;
                r_maxcnt <= '0;
                r_idx    <= '0;
            end
            bsrp_pkg::DP_SEL_NEXT: begin
                // next distinct score down the ranking
                r_rem    <= r_rem - r_maxcnt;
                r_cur    <= r_max;
                r_first  <= 1'b0;
                r_max_f  <= 1'b0;
                r_maxcnt <= '0;
                r_idx    <= '0;
            end
            bsrp_pkg::DP_SEL_DONE: begin
                r_thr <= r_max;
                r_idx <= '0;
            end
            bsrp_pkg::DP_CHK: begin
                r_idx <= r_idx + IW'(1);
                case (i_ctl.mode)
                    bsrp_pkg::SM_MATCH: begin
                        if (q_v && !r_match_f && q_key == r_key) begin
                            r_match_f <= 1'b1;
                            r_midx    <= r_idx;
                            r_mid     <= q_id;
                            r_msc     <= q_sc;
                        end
                        if (!q_v && !r_free_f) begin
                            r_free_f <= 1'b1;
                            r_fidx   <= r_idx;
                        end
                    end
                    bsrp_pkg::SM_QUERY: begin
                        if (q_v && (!r_qf || q_sc > r_qsc)) begin
                            r_qf  <= 1'b1;
                            r_qid <= q_id;
                            r_qsc <= q_sc;
                        end
                    end
                    bsrp_pkg::SM_COUNT: begin
                        if (q_v && q_cand) r_cnt <= r_cnt + CW'(1);
                    end
                    bsrp_pkg::SM_SEL: begin
                        if (q_v && q_cand && (r_first || q_sc < r_cur)) begin
                            if (!r_max_f || q_sc > r_max) begin
                                r_max    <= q_sc;
                                r_max_f  <= 1'b1;
                                r_maxcnt <= CW'(1);
                            end else if (q_sc == r_max) begin
                                r_maxcnt <= r_maxcnt + CW'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign o_valid        = r_ov;
    assign o_outcome      = r_ooc;
    assign o_entry_id     = r_oid;
    assign o_entry_score  = r_osc;
    assign o_entries_held = 6'(r_oheld);
    assign o_last         = r_olast;
endmodule

// File: rtl/beam_stack_recombine_prune_top.sv
// Hypothesis stack with recombination and lazy histogram pruning.
// Top level: sequencer plus datapath. Depends on bsrp_pkg, bsrp_ctrl, bsrp_dp.
//
// Input channel (i_valid/o_stall) takes one command word: add, clear or
// query best. Output channel (o_valid/i_stall) returns one or more result
// words per add, clear or query (none for the no-op code), o_last on the
// final one. Configuration writes (i_cfg_we/i_cfg_idx/i_cfg_data) are
// taken any cycle, meant while idle. One command at a time: o_stall is
// high from acceptance until the last word has entered the output
// register. Slots (2*MAX_KEEP) are scanned through the slot RAM, each
// slot with a read state and then a check state. A query makes one
// sweep; an add not below the worst score makes a match sweep, plus when
// pruning runs a sweep for the candidate count, a sweep per distinct
// score ranked while finding the threshold (at most the limit), and the
// eviction sweep. Each result word waits in a pending register so that
// o_last can be set. Reset empties the stack and restores register
// defaults. A stalling receiver holds the output word; the sequencer
// waits when the pending register is full and a stall holds the output word.
module beam_stack_recombine_prune_top #(
    parameter int MAX_KEEP = 16,
    parameter int KEY_BITS = 32,
    parameter int ID_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_cmd,
    input  logic [ID_BITS-1:0]   i_hypo_id,
    input  logic [KEY_BITS-1:0]  i_recomb_key,
    input  logic signed [31:0]   i_new_score,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_outcome,
    output logic [15:0]          o_entry_id,
    output logic signed [31:0]   o_entry_score,
    output logic [5:0]           o_entries_held,
    output logic                 o_last
);
    bsrp_pkg::t_ctl_cmd   ctl;
    bsrp_pkg::t_dp_status st;

    bsrp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_st   (st),
        .o_cmd  (ctl)
    );

    bsrp_dp #(.MAX_KEEP(MAX_KEEP), .KEY_BITS(KEY_BITS), .ID_BITS(ID_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_cmd),
        .i_hypo_id     (i_hypo_id),
        .i_recomb_key  (i_recomb_key),
        .i_new_score   (i_new_score),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_outcome     (o_outcome),
        .o_entry_id    (o_entry_id),
        .o_entry_score (o_entry_score),
        .o_entries_held(o_entries_held),
        .o_last        (o_last),
        .i_ctl         (ctl),
        .o_st          (st)
    );
endmodule

// File: test/beam_stack_recombine_prune_top_tb.sv
// Self-checking bench for beam_stack_recombine_prune_top: a table of directed
// commands followed by random add/clear/query traffic, each word checked
// against a behavioral model of the stack. Depends on bsrp_pkg and the RTL.
module beam_stack_recombine_prune_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 32;

    typedef struct packed {
        logic [2:0]         outcome;
        logic [15:0]        id;
        logic signed [31:0] score;
        logic [5:0]         held;
        logic               last;
    } t_result;

    typedef struct {
        logic [1:0]         cmd;
        logic [15:0]        id;
        logic [31:0]        key;
        logic signed [31:0] score;
        bit                 has_exp;
        logic [2:0]         exp_oc;
    } t_stim;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [1:0]         i_cfg_idx = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 0;
    logic               o_stall;
    logic [1:0]         i_cmd = '0;
    logic [15:0]        i_hypo_id = '0;
    logic [31:0]        i_recomb_key = '0;
    logic signed [31:0] i_new_score = '0;
    logic               o_valid;
    logic               i_stall = 0;
    logic [2:0]         o_outcome;
    logic [15:0]        o_entry_id;
    logic signed [31:0] o_entry_score;
    logic [5:0]         o_entries_held;
    logic               o_last;

    beam_stack_recombine_prune_top dut (.*);

    always #5 i_clk = ~i_clk;

    // model state
    bit                 m_valid [SLOTS];
    logic [31:0]        m_key   [SLOTS];
    logic signed [31:0] m_score [SLOTS];
    logic [15:0]        m_id    [SLOTS];
    logic signed [31:0] m_best, m_worst, m_beam;
    int unsigned        m_held, m_limit;
    bit                 m_pdis;

    t_result     pending_words[$];
    int          errors = 0;
    int          words_seen = 0, evictions = 0;
    longint      cycle = 0;
    bit          quiet = 0;      // stretch with no idling
    int          idle_pct = 28;

    function automatic logic signed [31:0] sadd(logic signed [31:0] a,
                                                logic signed [31:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (s < -64'sd2147483648) return bsrp_pkg::SCORE_MIN;
        return s[31:0];
    endfunction

    function automatic int unsigned lim_eff();
        if (m_limit < 1) return 1;
        if (m_limit > 16) return 16;
        return m_limit;
    endfunction

    function automatic bit in_beam(logic signed [31:0] sc);
        if (m_beam == bsrp_pkg::SCORE_MIN) return 1;
        return sc > sadd(m_best, m_beam);
    endfunction

    function automatic void push_word(logic [2:0] oc, logic [15:0] id,
                                      logic signed [31:0] sc);
        t_result r;
        r.outcome = oc; r.id = id; r.score = sc; r.held = m_held[5:0]; r.last = 0;
        pending_words.push_back(r);
    endfunction

    function automatic void prune_stack();
        int unsigned k, cand, gt, ge;
        logic signed [31:0] thr;
        bit found;
        cand = 0; found = 0; thr = 0;
        if (m_held <= lim_eff()) return;
        for (int i = 0; i < SLOTS; i++)
            if (m_valid[i] && in_beam(m_score[i])) cand++;
        if (cand == 0) return;
        k = lim_eff() < cand ? lim_eff() : cand;
        for (int i = 0; i < SLOTS && !found; i++) begin
            if (!m_valid[i] || !in_beam(m_score[i])) continue;
            gt = 0; ge = 0;
            for (int j = 0; j < SLOTS; j++) begin
                if (!m_valid[j] || !in_beam(m_score[j])) continue;
                if (m_score[j] > m_score[i]) gt++;
                if (m_score[j] >= m_score[i]) ge++;
            end
            if (gt < k && k <= ge) begin
                thr = m_score[i];
                found = 1;
            end
        end
        if (!found) return;
        for (int i = 0; i < SLOTS; i++) begin
            if (m_valid[i] && m_score[i] < thr) begin
                m_valid[i] = 0;
                m_held--;
                evictions++;
                push_word(bsrp_pkg::OC_EVICTED, m_id[i], m_score[i]);
            end
        end
        m_worst = thr;
    endfunction

    function automatic void note_insert(logic signed [31:0] sc);
        if (sc > m_best) begin
            m_best = sc;
            if (m_beam != bsrp_pkg::SCORE_MIN && sadd(m_best, m_beam) > m_worst)
                m_worst = sadd(m_best, m_beam);
        end
        if (!m_pdis && m_held > 2 * lim_eff() - 1) prune_stack();
    endfunction

    // returns number of words queued for this command
    function automatic int predict_stack(t_stim s);
        int n0, match, free_slot, best;
        n0 = pending_words.size();
        match = -1; free_slot = -1; best = -1;
        case (s.cmd)
            bsrp_pkg::CMD_ADD: begin
                if (s.score < m_worst) push_word(bsrp_pkg::OC_BELOW, s.id, s.score);
                else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (m_valid[i] && match < 0 && m_key[i] == s.key) match = i;
                        if (!m_valid[i] && free_slot < 0) free_slot = i;
                    end
                    if (match >= 0) begin
                        if (s.score > m_score[match]) begin
                            push_word(bsrp_pkg::OC_REPLACED, m_id[match], m_score[match]);
                            m_id[match] = s.id;
                            m_score[match] = s.score;
                            note_insert(s.score);
                        end else begin
                            push_word(bsrp_pkg::OC_DROPPED, m_id[match], m_score[match]);
                        end
                    end else if (free_slot < 0) begin
                        push_word(bsrp_pkg::OC_BELOW, s.id, s.score);
                    end else begin
                        m_valid[free_slot] = 1;
                        m_key[free_slot] = s.key;
                        m_score[free_slot] = s.score;
                        m_id[free_slot] = s.id;
                        m_held++;
                        push_word(bsrp_pkg::OC_ADDED, s.id, s.score);
                        note_insert(s.score);
                    end
                end
            end
            bsrp_pkg::CMD_CLEAR: begin
                foreach (m_valid[i]) m_valid[i] = 0;
                m_held = 0;
                push_word(bsrp_pkg::OC_CLEARED, 0, 0);
            end
            bsrp_pkg::CMD_QUERY: begin
                for (int i = 0; i < SLOTS; i++)
                    if (m_valid[i] && (best < 0 || m_score[i] > m_score[best])) best = i;
                if (best < 0) push_word(bsrp_pkg::OC_EMPTY, 0, 0);
                else push_word(bsrp_pkg::OC_BEST, m_id[best], m_score[best]);
            end
            default: ;
        endcase
        if (pending_words.size() > n0) pending_words[$].last = 1;
        return pending_words.size() - n0;
    endfunction

    // output side: random stall, check each accepted word
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                words_seen++;
                if (pending_words.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word oc=%0d id=%0d", o_outcome, o_entry_id);
                end else begin
                    t_result e;
                    e = pending_words.pop_front();
                    if (e.outcome !== o_outcome || e.id !== o_entry_id
                        || e.score !== o_entry_score
                        || e.held !== o_entries_held || e.last !== o_last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch exp oc=%0d id=%0d sc=%0d held=%0d last=%0d,",
                                      " got oc=%0d id=%0d sc=%0d held=%0d last=%0d"},
                                     e.outcome, e.id, e.score, e.held, e.last,
                                     o_outcome, o_entry_id, o_entry_score,
                                     o_entries_held, o_last);
                    end
                end
            end
            i_stall <= quiet ? 1'b0 : ($urandom_range(99) < idle_pct);
        end
        if (cycle > 2_000_000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            bsrp_pkg::REG_BEAM:  m_beam = val;
            bsrp_pkg::REG_LIMIT: m_limit = val[4:0];
            bsrp_pkg::REG_PDIS:  m_pdis = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_words();
        while (pending_words.size() != 0) @(posedge i_clk);
        // adds that refuse still scan; give the block its full latency
        repeat (400) @(posedge i_clk);
    endtask

    task automatic send_word(t_stim s);
        while (!quiet && $urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; i_cmd <= s.cmd; i_hypo_id <= s.id;
        i_recomb_key <= s.key; i_new_score <= s.score;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        void'(predict_stack(s));
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic t_stim mk(logic [1:0] c, logic [15:0] id, logic [31:0] k,
                                 logic signed [31:0] sc);
        t_stim s;
        s.cmd = c; s.id = id; s.key = k; s.score = sc; s.has_exp = 0; s.exp_oc = '0;
        return s;
    endfunction

    function automatic t_stim rnd_add(int keyspace);
        t_stim s;
        s = mk(bsrp_pkg::CMD_ADD, 16'($urandom), $urandom_range(keyspace - 1),
               $signed($urandom_range(40000)) - 20000);
        if ($urandom_range(9) == 0) s.score = $urandom;
        if ($urandom_range(9) == 0) s.key = $urandom;
        return s;
    endfunction

    t_stim table_rows[$];
    t_stim s;

    initial begin
        foreach (m_valid[i]) m_valid[i] = 0;
        m_held = 0; m_best = bsrp_pkg::SCORE_MIN; m_worst = bsrp_pkg::SCORE_MIN;
        m_beam = bsrp_pkg::SCORE_MIN; m_limit = 16; m_pdis = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed table; expected outcome typed only where obvious
        s = mk(bsrp_pkg::CMD_QUERY, 0, 0, 0);
        s.has_exp = 1; s.exp_oc = bsrp_pkg::OC_EMPTY; table_rows.push_back(s);
        table_rows.push_back(mk(bsrp_pkg::CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF));
        table_rows.push_back(mk(bsrp_pkg::CMD_ADD, 16'h0000, 32'h0, bsrp_pkg::SCORE_MIN));
        table_rows.push_back(mk(bsrp_pkg::CMD_ADD, 16'h1234, 32'hFFFF_FFFF, 0)); // dropped
        table_rows.push_back(mk(bsrp_pkg::CMD_ADD, 16'h5555, 32'h0, 32'sh0001_0000));
        table_rows.push_back(mk(bsrp_pkg::CMD_ADD, 16'hAAAA, 32'h0, 32'sh0001_0000)); // tie
        table_rows.push_back(mk(bsrp_pkg::CMD_QUERY, 0, 0, 0));
        table_rows.push_back(mk(bsrp_pkg::CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF, -1)); // no-op
        s = mk(bsrp_pkg::CMD_CLEAR, 0, 0, 0);
        s.has_exp = 1; s.exp_oc = bsrp_pkg::OC_CLEARED; table_rows.push_back(s);
        table_rows.push_back(mk(bsrp_pkg::CMD_ADD, 16'h0001, 32'h1, 32'sh0002_0000));
        table_rows.push_back(mk(bsrp_pkg::CMD_ADD, 16'h0002, 32'h2, 32'sh0002_0000));
        table_rows.push_back(mk(bsrp_pkg::CMD_QUERY, 0, 0, 0));
        for (int i = 0; i < table_rows.size(); i++) begin
            send_word(table_rows[i]);
            if (table_rows[i].has_exp && pending_words.size() > 0
                && pending_words[$].outcome !== table_rows[i].exp_oc) begin
                errors++;
                $display("table row %0d: model gives %0d, table %0d", i,
                         pending_words[$].outcome, table_rows[i].exp_oc);
            end
        end
        drain_words();

        // small limit, beam on; the best score kept from the table puts every entry outside the beam, so no pruning
        write_reg(bsrp_pkg::REG_LIMIT, 32'd2);
        write_reg(bsrp_pkg::REG_BEAM, 32'shFFFF_0000);
        send_word(mk(bsrp_pkg::CMD_CLEAR, 0, 0, 0));
        for (int i = 0; i < 6; i++)
            send_word(mk(bsrp_pkg::CMD_ADD, 16'(i + 10), 32'(100 + i), 32'(i * 32'sh4000)));
        send_word(mk(bsrp_pkg::CMD_ADD, 16'h00EE, 32'h77, bsrp_pkg::SCORE_MIN));
        drain_words();

        // full stack with pruning off, then refused add
        write_reg(bsrp_pkg::REG_PDIS, 32'd1);
        write_reg(bsrp_pkg::REG_BEAM, bsrp_pkg::SCORE_MIN);
        send_word(mk(bsrp_pkg::CMD_CLEAR, 0, 0, 0));
        for (int i = 0; i < 33; i++)
            send_word(mk(bsrp_pkg::CMD_ADD, 16'(i), 32'(1000 + i), 32'(i)));
        drain_words();

        // random phases through several settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(bsrp_pkg::REG_PDIS, 0);
                    write_reg(bsrp_pkg::REG_LIMIT, 32'd1);
                    write_reg(bsrp_pkg::REG_BEAM, 32'sh8000_0001);
                end
                1: begin
                    write_reg(bsrp_pkg::REG_LIMIT, 32'd16);
                    write_reg(bsrp_pkg::REG_BEAM, 0);
                end
                2: begin
                    write_reg(bsrp_pkg::REG_LIMIT, 32'd0);
                    write_reg(bsrp_pkg::REG_BEAM, 32'shFFF0_0000);
                end
                3: begin
                    write_reg(bsrp_pkg::REG_LIMIT, 32'd31);
                    write_reg(bsrp_pkg::REG_PDIS, 1);
                end
                default: begin
                    write_reg(bsrp_pkg::REG_LIMIT, 32'd4);
                    write_reg(bsrp_pkg::REG_PDIS, 0);
                    write_reg(bsrp_pkg::REG_BEAM, bsrp_pkg::SCORE_MIN);
                end
            endcase
            quiet = (ph == 1);
            send_word(mk(bsrp_pkg::CMD_CLEAR, 0, 0, 0));
            for (int i = 0; i < 10; i++) begin
                case ($urandom_range(19))
                    0: s = mk(bsrp_pkg::CMD_CLEAR, 16'($urandom), $urandom, $urandom);
                    1, 2: s = mk(bsrp_pkg::CMD_QUERY, 16'($urandom), $urandom, $urandom);
                    3: s = mk(bsrp_pkg::CMD_NONE, 16'($urandom), $urandom, $urandom);
                    default: s = rnd_add(24);
                endcase
                send_word(s);
            end
            // sender holds off until the block has caught up
            if (ph == 2) while (pending_words.size() != 0) @(posedge i_clk);
            drain_words();
        end
        quiet = 0;

        drain_words();
        $display("ran directed table plus 5 random phases; %0d result words, %0d evictions",
                 words_seen, evictions);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
